// ===== hw/rtl/lat_pkg.sv =====
// ----------------------------------------------------------------------------
// lat_pkg
// Types and constants shared by the load average tracker modules.
// ----------------------------------------------------------------------------
package lat_pkg;

   localparam int NUM_SETS_DEF    = 8;
   localparam int MAX_CPUS        = 64;
   localparam int SCALE_FACTOR    = 1000;
   localparam int SCHED_FRAC_BITS = 7;
   localparam int BUSY_MAX        = 65535;

   localparam int SCALE_W = $clog2(SCALE_FACTOR + 1);
   localparam int PROD_W  = 26 + SCALE_W;
   localparam int DVS_W   = 17;
   localparam int QUEUE_DEPTH = 2;

   // reciprocals for the constant divisions, exact over the dividend ranges used
   localparam int          RCP_W     = PROD_W + 1;
   localparam int          RCP_SH    = PROD_W + SCALE_W;
   localparam logic [63:0] RCP_SCALE = ((64'd1 << RCP_SH) + 64'(SCALE_FACTOR) - 64'd1)
                                       / 64'(SCALE_FACTOR);
   localparam int          RCP5_SH   = 32;
   localparam logic [63:0] RCP_FIVE  = ((64'd1 << RCP5_SH) + 64'd4) / 64'd5;

   localparam logic [7:0] CSR_DEFAULT_SET  = 8'd0;
   localparam logic [7:0] CSR_DECAY_SHORT  = 8'd1;
   localparam logic [7:0] CSR_DECAY_MEDIUM = 8'd2;
   localparam logic [7:0] CSR_DECAY_LONG   = 8'd3;

   typedef struct packed {
      logic [2:0]  set_index;
      logic [6:0]  cpu_count;
      logic [15:0] queued_threads;
      logic [6:0]  idle_cpus;
   } req_type;

   typedef struct packed {
      logic [2:0]  set_index_res;
      logic        updated;
      logic [15:0] set_factor_avg;
      logic [25:0] set_load_avg;
      logic [22:0] sched_avg;
      logic [15:0] factor_short;
      logic [15:0] factor_medium;
      logic [15:0] factor_long;
      logic [25:0] run_avg_short;
      logic [25:0] run_avg_medium;
      logic [25:0] run_avg_long;
   } rsp_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [9:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [2:0] default_set;
      logic [9:0] decay_short;
      logic [9:0] decay_medium;
      logic [9:0] decay_long;
   } cfg_type;

   // classified sample handed from front to back
   typedef struct packed {
      logic [2:0]  set_index;
      logic        valid_set;
      logic        upd;
      logic        is_def;
      logic [6:0]  cpus;
      logic [15:0] busy;
   } job_type;

endpackage

// ===== hw/rtl/lat_chan_if.sv =====
// ----------------------------------------------------------------------------
// lat_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lat_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lat_divider.sv =====
// ----------------------------------------------------------------------------
// lat_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lat_divider
   import lat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(PROD_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[PROD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(PROD_W);
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         // quotient bits shift in where dividend bits leave
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule

// ===== hw/rtl/lat_queue.sv =====
// ----------------------------------------------------------------------------
// lat_queue
// Short FIFO between the classifying front and the computing back.
// ----------------------------------------------------------------------------
module lat_queue
   import lat_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
endmodule

// ===== hw/rtl/lat_front.sv =====
// ----------------------------------------------------------------------------
// lat_front
// Accepts samples, clamps counts and forms the saturated busy-thread count.
// ----------------------------------------------------------------------------
module lat_front
   import lat_pkg::*;
#(
   parameter int NUM_SETS = NUM_SETS_DEF
)
(
   lat_chan_if.sink   req_if,
   input  logic [2:0] default_set,
   input  logic       q_full,
   output logic       push,
   output job_type    job
);
   logic [6:0]  cpus_c;
   logic [6:0]  idle_c;
   logic [16:0] sum;
   logic [16:0] sum_adj;
   logic        is_def;

   always_comb begin
      cpus_c  = (req_if.data.cpu_count > 7'(MAX_CPUS)) ? 7'(MAX_CPUS)
                                                       : req_if.data.cpu_count;
      idle_c  = (req_if.data.idle_cpus > cpus_c) ? cpus_c : req_if.data.idle_cpus;
      is_def  = (req_if.data.set_index == default_set);
      sum     = {1'b0, req_if.data.queued_threads} + 17'(cpus_c - idle_c);
      sum_adj = (is_def && sum != '0) ? sum - 1'b1 : sum;

      job.set_index = req_if.data.set_index;
      job.valid_set = (32'(req_if.data.set_index) < NUM_SETS);
      job.upd       = job.valid_set && (req_if.data.cpu_count != '0);
      job.is_def    = is_def;
      job.cpus      = cpus_c;
      job.busy      = (sum_adj > 17'(BUSY_MAX)) ? 16'(BUSY_MAX) : sum_adj[15:0];
   end

   assign req_if.ready = !q_full;
   assign push         = req_if.valid && !q_full;
endmodule

// ===== hw/rtl/lat_back.sv =====
// ----------------------------------------------------------------------------
// lat_back
// Sequencer over one multiplier, one divider and a reciprocal unit that
// updates the per-set and global averages and fills the result register.
// ----------------------------------------------------------------------------
module lat_back
   import lat_pkg::*;
#(
   parameter int NUM_SETS = NUM_SETS_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_not_empty,
   input  job_type  q_head,
   output logic     q_pop,
   lat_chan_if.source rsp_if
);
   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int HALF_W = PROD_W / 2;
   localparam int HI_W   = PROD_W - HALF_W;
   localparam int ACC_W  = PROD_W + RCP_W;
   localparam int PP_W   = HI_W + RCP_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_AVG   = 4'd1;
   localparam logic [3:0] ST_FACT  = 4'd2;
   localparam logic [3:0] ST_FSET  = 4'd3;
   localparam logic [3:0] ST_FDIV  = 4'd4;
   localparam logic [3:0] ST_LDIV  = 4'd5;
   localparam logic [3:0] ST_SF    = 4'd6;
   localparam logic [3:0] ST_SL    = 4'd7;
   localparam logic [3:0] ST_GMUL0 = 4'd8;
   localparam logic [3:0] ST_GMUL1 = 4'd9;
   localparam logic [3:0] ST_GDIV  = 4'd10;
   localparam logic [3:0] ST_SCHED = 4'd11;
   localparam logic [3:0] ST_OUT   = 4'd12;

   logic [3:0]        st_ff;
   logic              pend_ff;
   job_type           job_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [15:0]       factor_ff;
   logic [22:0]       load_ff;
   logic [25:0]       avg_ff;
   logic [1:0]        gi_ff;
   logic              gsel_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [15:0] fac_mem_ff   [NUM_SETS];
   logic [25:0] load_mem_ff  [NUM_SETS];
   logic [22:0] sched_mem_ff [NUM_SETS];
   logic [15:0] gf_ff [3];
   logic [25:0] gr_ff [3];

   logic [SET_W-1:0]  sel;
   logic [25:0]       mul_a;
   logic [SCALE_W-1:0] mul_b;
   logic [PROD_W-1:0] prod_in;
   logic [9:0]        d_raw;
   logic [SCALE_W-1:0] k;
   logic              div_start;
   logic [PROD_W-1:0] div_dvd;
   logic [DVS_W-1:0]  div_dvs;
   logic              div_done;
   logic [PROD_W-1:0] div_q;
   logic [23:0]       sched_sum;

   // constant divisions by five and by the scale factor
   logic              cd_start;
   logic              cd_big;
   logic [PROD_W-1:0] cd_dvd;
   logic [1:0]        cd_step_ff;
   logic              cd_done_ff;
   logic              cd_big_ff;
   logic [PROD_W-1:0] cd_x_ff;
   logic [ACC_W-1:0]  cd_acc_ff;
   logic [RCP_W-1:0]  cd_m;
   logic [HI_W-1:0]   cd_half;
   logic [PP_W-1:0]   cd_prod;
   logic [25:0]       cd_q;

   assign sel = SET_W'(job_ff.set_index);

   always_comb begin
      case (gi_ff)
         2'd0:    d_raw = cfg.decay_short;
         2'd1:    d_raw = cfg.decay_medium;
         default: d_raw = cfg.decay_long;
      endcase
      k = (32'(d_raw) > SCALE_FACTOR) ? SCALE_W'(SCALE_FACTOR) : SCALE_W'(d_raw);
   end

   // single shared multiplier
   always_comb begin
      case (st_ff)
         ST_AVG: begin
            mul_a = 26'(job_ff.busy);
            mul_b = SCALE_W'(SCALE_FACTOR);
         end
         ST_FACT: begin
            mul_a = (job_ff.busy > 16'(job_ff.cpus)) ? 26'(job_ff.cpus)
                                                     : 26'(16'(job_ff.cpus) - job_ff.busy);
            mul_b = SCALE_W'(SCALE_FACTOR);
         end
         ST_GMUL0: begin
            mul_a = gsel_ff ? gr_ff[gi_ff] : 26'(gf_ff[gi_ff]);
            mul_b = k;
         end
         ST_GMUL1: begin
            mul_a = gsel_ff ? avg_ff : 26'(factor_ff);
            mul_b = SCALE_W'(SCALE_FACTOR) - k;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      case (st_ff)
         ST_FDIV: begin
            div_dvd = prod_ff;
            div_dvs = DVS_W'(job_ff.busy) + 1'b1;
         end
         ST_LDIV: begin
            div_dvd = PROD_W'({job_ff.busy, SCHED_FRAC_BITS'(0)});
            div_dvs = DVS_W'(job_ff.cpus);
         end
         default: begin
            div_dvd = '0;
            div_dvs = DVS_W'(1);
         end
      endcase
      case (st_ff)
         ST_SF: begin
            cd_dvd = (PROD_W'(fac_mem_ff[sel]) << 2) + PROD_W'(factor_ff);
            cd_big = 1'b0;
         end
         ST_SL: begin
            cd_dvd = (PROD_W'(load_mem_ff[sel]) << 2) + PROD_W'(avg_ff);
            cd_big = 1'b0;
         end
         ST_GDIV: begin
            cd_dvd = acc_ff + prod_ff;
            cd_big = 1'b1;
         end
         default: begin
            cd_dvd = '0;
            cd_big = 1'b0;
         end
      endcase
      div_start = !pend_ff && (st_ff == ST_FDIV || st_ff == ST_LDIV);
      cd_start  = !pend_ff && (st_ff == ST_SF || st_ff == ST_SL || st_ff == ST_GDIV);
      sched_sum = {1'b0, sched_mem_ff[sel]} + {1'b0, load_ff};
   end

   // reciprocal multiply in two halves of the dividend
   always_comb begin
      cd_m    = cd_big_ff ? RCP_W'(RCP_SCALE) : RCP_W'(RCP_FIVE);
      cd_half = (cd_step_ff == 2'd1) ? HI_W'(cd_x_ff[HALF_W-1:0]) : cd_x_ff[PROD_W-1:HALF_W];
      cd_prod = PP_W'(cd_half) * PP_W'(cd_m);
      cd_q    = cd_big_ff ? cd_acc_ff[RCP_SH +: 26] : cd_acc_ff[RCP5_SH +: 26];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_step_ff <= 2'd0;
         cd_done_ff <= 1'b0;
      end else begin
         cd_done_ff <= (cd_step_ff == 2'd2);
         if (cd_start) begin
            cd_step_ff <= 2'd1;
         end else if (cd_step_ff == 2'd1) begin
            cd_step_ff <= 2'd2;
         end else if (cd_step_ff == 2'd2) begin
            cd_step_ff <= 2'd0;
         end
      end
      if (cd_start) begin
         cd_x_ff   <= cd_dvd;
         cd_big_ff <= cd_big;
      end
      if (cd_step_ff == 2'd1) begin
         cd_acc_ff <= ACC_W'(cd_prod);
      end else if (cd_step_ff == 2'd2) begin
         cd_acc_ff <= cd_acc_ff + (ACC_W'(cd_prod) << HALF_W);
      end
   end

   lat_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_pop = (st_ff == ST_IDLE) && q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pend_ff      <= 1'b0;
         gi_ff        <= '0;
         gsel_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SETS; i++) begin
            fac_mem_ff[i]   <= '0;
            load_mem_ff[i]  <= '0;
            sched_mem_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            gf_ff[i] <= '0;
            gr_ff[i] <= '0;
         end
      end else begin
         if (div_start || cd_start) begin
            pend_ff <= 1'b1;
         end else if (div_done || cd_done_ff) begin
            pend_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (q_not_empty) begin
                  job_ff <= q_head;
                  st_ff  <= q_head.upd ? ST_AVG : ST_OUT;
               end
            end
            ST_AVG: begin
               prod_ff <= prod_in;
               st_ff   <= ST_FACT;
            end
            ST_FACT: begin
               avg_ff  <= prod_ff[25:0];
               prod_ff <= prod_in;
               st_ff   <= (job_ff.busy > 16'(job_ff.cpus)) ? ST_FDIV : ST_FSET;
            end
            ST_FSET: begin
               factor_ff <= prod_ff[15:0];
               load_ff   <= 23'(1) << SCHED_FRAC_BITS;
               st_ff     <= ST_SF;
            end
            ST_FDIV: begin
               if (div_done) begin
                  factor_ff <= div_q[15:0];
                  st_ff     <= ST_LDIV;
               end
            end
            ST_LDIV: begin
               if (div_done) begin
                  load_ff <= div_q[22:0];
                  st_ff   <= ST_SF;
               end
            end
            ST_SF: begin
               if (cd_done_ff) begin
                  fac_mem_ff[sel] <= cd_q[15:0];
                  st_ff           <= ST_SL;
               end
            end
            ST_SL: begin
               if (cd_done_ff) begin
                  load_mem_ff[sel] <= cd_q;
                  gi_ff            <= '0;
                  gsel_ff          <= 1'b0;
                  st_ff            <= job_ff.is_def ? ST_GMUL0 : ST_SCHED;
               end
            end
            ST_GMUL0: begin
               prod_ff <= prod_in;
               st_ff   <= ST_GMUL1;
            end
            ST_GMUL1: begin
               acc_ff  <= prod_ff;
               prod_ff <= prod_in;
               st_ff   <= ST_GDIV;
            end
            ST_GDIV: begin
               if (cd_done_ff) begin
                  if (gsel_ff) begin
                     gr_ff[gi_ff] <= cd_q;
                     gsel_ff      <= 1'b0;
                     if (gi_ff == 2'd2) begin
                        st_ff <= ST_SCHED;
                     end else begin
                        gi_ff <= gi_ff + 1'b1;
                        st_ff <= ST_GMUL0;
                     end
                  end else begin
                     gf_ff[gi_ff] <= cd_q[15:0];
                     gsel_ff      <= 1'b1;
                     st_ff        <= ST_GMUL0;
                  end
               end
            end
            ST_SCHED: begin
               sched_mem_ff[sel] <= sched_sum[23:1];
               st_ff             <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
      if (st_ff == ST_OUT && !rsp_valid_ff) begin
         rsp_ff.set_index_res  <= job_ff.set_index;
         rsp_ff.updated        <= job_ff.upd;
         rsp_ff.set_factor_avg <= job_ff.valid_set ? fac_mem_ff[sel] : '0;
         rsp_ff.set_load_avg   <= job_ff.valid_set ? load_mem_ff[sel] : '0;
         rsp_ff.sched_avg      <= job_ff.valid_set ? sched_mem_ff[sel] : '0;
         rsp_ff.factor_short   <= gf_ff[0];
         rsp_ff.factor_medium  <= gf_ff[1];
         rsp_ff.factor_long    <= gf_ff[2];
         rsp_ff.run_avg_short  <= gr_ff[0];
         rsp_ff.run_avg_medium <= gr_ff[1];
         rsp_ff.run_avg_long   <= gr_ff[2];
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;
endmodule

// ===== hw/rtl/load_average_tracker_top.sv =====
// ----------------------------------------------------------------------------
// load_average_tracker_top
// Per-set and global exponential load and availability averages.
// ----------------------------------------------------------------------------
// One sample per processor set goes in on req_if and one result beat comes
// out on rsp_if. Samples are classified on entry and queued two deep; the
// back end then works one sample at a time through a single multiplier, a
// bit-serial 36-bit divider for the two variable divisions and a reciprocal
// multiply for the divisions by five and by the scale factor. An empty or
// unknown set goes straight to its result, a set with no more busy threads
// than processors skips the divider, an overloaded set uses both variable
// divisions, and the default set also updates the global averages for all
// three decays. The back end pops a new sample only after raising the last
// one's result. A result not yet taken holds the back end while the queue
// keeps accepting until full. Registers on csr_if are written in one cycle
// and should only be written while the block is idle.
module load_average_tracker_top
   import lat_pkg::*;
#(
   parameter int NUM_SETS = NUM_SETS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   lat_chan_if.sink   req_if,
   lat_chan_if.source rsp_if,
   lat_chan_if.sink   csr_if
);
   cfg_type cfg_ff;
   logic    push;
   job_type job;
   logic    q_full;
   logic    q_pop;
   logic    q_not_empty;
   job_type q_head;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_set  <= 3'd0;
         cfg_ff.decay_short  <= 10'd800;
         cfg_ff.decay_medium <= 10'd966;
         cfg_ff.decay_long   <= 10'd983;
      end else if (csr_if.valid) begin
         case (csr_if.data.addr)
            CSR_DEFAULT_SET:  cfg_ff.default_set  <= csr_if.data.wdata[2:0];
            CSR_DECAY_SHORT:  cfg_ff.decay_short  <= csr_if.data.wdata;
            CSR_DECAY_MEDIUM: cfg_ff.decay_medium <= csr_if.data.wdata;
            CSR_DECAY_LONG:   cfg_ff.decay_long   <= csr_if.data.wdata;
            default: ;
         endcase
      end
   end

   lat_front #(.NUM_SETS(NUM_SETS)) u_front (
      .req_if      (req_if),
      .default_set (cfg_ff.default_set),
      .q_full      (q_full),
      .push        (push),
      .job         (job)
   );

   lat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   lat_back #(.NUM_SETS(NUM_SETS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_if      (rsp_if)
   );
endmodule
